@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define FPA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle, outside reset.
`define FPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Default number of fraction bits
    localparam int FPA_FRAC_BITS = 8;

    // Operation codes
    typedef enum logic [3:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_DIV      = 4'd3,
        KIND_MIN      = 4'd4,
        KIND_MAX      = 4'd5,
        KIND_INC      = 4'd6,
        KIND_DEC      = 4'd7,
        KIND_FROM_INT = 4'd8,
        KIND_TO_INT   = 4'd9
    } t_kind;

    // One operation item
    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               div_by_zero;
    } t_out_item;

    // Side results that travel beside the multiplier and the divider
    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] res_simple;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               div_by_zero;
    } t_side;

endpackage

@@ rtl/fpa_ifs.sv @@
// ----------------------------------------------------------------------------
// fpa_ifs
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface fpa_in_if import fpa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fpa_mul_pipe.sv @@
// ----------------------------------------------------------------------------
// fpa_mul_pipe
// Signed 32x32 product, rescaled by the fraction bits, delayed to the
// common pipeline latency.
// ----------------------------------------------------------------------------
module fpa_mul_pipe import fpa_pkg::*; #(
    parameter int FRAC_BITS = FPA_FRAC_BITS,
    parameter int LAT       = 32 + FPA_FRAC_BITS + 2
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_prod
);

    logic signed [63:0] r_prod;
    logic signed [31:0] r_dly [0:LAT-2];

    // Form the full-width product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // Take the rescaled low word, then delay it to the common latency
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r_prod[FRAC_BITS+31:FRAC_BITS];
            for (int k = 1; k < LAT - 1; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_prod = r_dly[LAT-2];

endmodule

@@ rtl/fpa_div_pipe.sv @@
// ----------------------------------------------------------------------------
// fpa_div_pipe
// Pipelined restoring divider: (a * 2^FRAC_BITS) / b, truncated toward zero,
// one quotient bit per stage, low 32 bits kept.
// ----------------------------------------------------------------------------
module fpa_div_pipe import fpa_pkg::*; #(
    parameter int FRAC_BITS = FPA_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_quot
);

    localparam int DW = 32 + FRAC_BITS;

    logic [31:0]        n_mag_a;
    logic [31:0]        n_mag_b;
    logic [31:0]        r_mag_a;
    logic [31:0]        r_mag_b;
    logic               r_neg_a;
    logic [31:0]        r_rem [0:DW-1];
    logic [DW-1:0]      r_dq  [0:DW-1];
    logic [31:0]        r_dvs [0:DW-1];
    logic               r_neg [0:DW-1];
    logic [31:0]        n_quot;
    logic signed [31:0] r_quot;

    // Take magnitudes; the sign of the quotient follows the operand signs
    always_comb begin
        n_mag_a = i_a[31] ? (~i_a + 32'd1) : i_a;
        n_mag_b = i_b[31] ? (~i_b + 32'd1) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
            r_neg_a <= i_a[31] ^ i_b[31];
        end
    end

    // One trial subtraction per stage; dividend bits shift out, quotient bits in
    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [31:0]   rem_in;
        logic [DW-1:0] dq_in;
        logic [31:0]   dvs_in;
        logic          neg_in;
        logic [32:0]   shifted;
        logic [32:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = {r_mag_a, {FRAC_BITS{1'b0}}};
            assign dvs_in = r_mag_b;
            assign neg_in = r_neg_a;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dq_in  = r_dq[k-1];
            assign dvs_in = r_dvs[k-1];
            assign neg_in = r_neg[k-1];
        end

        assign shifted = {rem_in, dq_in[DW-1]};
        assign diff    = shifted - {1'b0, dvs_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= diff[32] ? shifted[31:0] : diff[31:0];
                r_dq[k]  <= {dq_in[DW-2:0], ~diff[32]};
                r_dvs[k] <= dvs_in;
                r_neg[k] <= neg_in;
            end
        end
    end

    // Restore the sign on the low quotient word
    always_comb begin
        n_quot = r_neg[DW-1] ? (~r_dq[DW-1][31:0] + 32'd1) : r_dq[DW-1][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

@@ rtl/fpa_out_buf.sv @@
// ----------------------------------------------------------------------------
// fpa_out_buf
// Two-entry output buffer; keeps the pipeline moving while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpa_out_buf import fpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_out_item        i_item,
    output logic             o_full,
    fpa_out_if.source        o_res
);

    t_out_item  r_mem [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop    = o_res.valid && o_res.ready;
    assign o_full = (r_cnt == 2'd2);

    // Track the fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Store the incoming item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_res.valid = (r_cnt != 2'd0);
    assign o_res.data  = r_mem[r_rd];

    `FPA_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, r_cnt == 2'd2, !i_push, "push into full buffer")
    `FPA_ASSERT_CLK(a_pop_count, i_clk, i_rst_n, (pop && !i_push) |=> (r_cnt == $past(r_cnt) - 2'd1), "fill level lost a pop")

endmodule

@@ rtl/fixed_point_alu_q24_8.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec and
// integer conversions, with compare flags and a divide-by-zero flag.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  i_op     | in        | kind, operand_a, operand_b
//  o_res    | out       | result_raw, a_less, a_equal, a_greater, div_by_zero
//
// One item enters per cycle while the output buffer is not full. The pipeline
// depth is set by the divider, which spends one stage per quotient bit over the
// 32 + FRAC_BITS bit dividend.
// Reset clears the valid bits and the output buffer; payload is not reset.
// The whole pipeline halts while the two-entry output buffer is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_point_alu_q24_8 import fpa_pkg::*; #(
    parameter int FRAC_BITS = FPA_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_op,
    fpa_out_if.source o_res
);

    localparam int LAT = 32 + FRAC_BITS + 2;

    logic               en;
    logic               full;
    logic               r_v [0:LAT];
    t_in_item           r_s0;
    t_side              n_side;
    t_side              r_side [1:LAT];
    logic signed [31:0] prod;
    logic signed [31:0] quot;
    t_out_item          n_out;
    logic               push;

    assign en         = !full;
    assign i_op.ready = en;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_op.valid;
            for (int k = 1; k <= LAT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_op.data;
        end
    end

    // Compute the flags and the results of the simple operations
    always_comb begin
        n_side.kind        = r_s0.kind;
        n_side.a_less      = r_s0.operand_a < r_s0.operand_b;
        n_side.a_equal     = r_s0.operand_a == r_s0.operand_b;
        n_side.a_greater   = r_s0.operand_a > r_s0.operand_b;
        n_side.div_by_zero = (r_s0.kind == KIND_DIV) && (r_s0.operand_b == 32'sd0);
        case (r_s0.kind)
            KIND_ADD:      n_side.res_simple = r_s0.operand_a + r_s0.operand_b;
            KIND_SUB:      n_side.res_simple = r_s0.operand_a - r_s0.operand_b;
            KIND_MIN:      n_side.res_simple = n_side.a_less ? r_s0.operand_a
                                                             : r_s0.operand_b;
            KIND_MAX:      n_side.res_simple = n_side.a_greater ? r_s0.operand_a
                                                                : r_s0.operand_b;
            KIND_INC:      n_side.res_simple = r_s0.operand_a + 32'sd1;
            KIND_DEC:      n_side.res_simple = r_s0.operand_a - 32'sd1;
            KIND_FROM_INT: n_side.res_simple = {r_s0.operand_a[31-FRAC_BITS:0],
                                                {FRAC_BITS{1'b0}}};
            KIND_TO_INT:   n_side.res_simple = r_s0.operand_a >>> FRAC_BITS;
            default:       n_side.res_simple = '0;
        endcase
    end

    // Delay the side results alongside the long units
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= n_side;
            for (int k = 2; k <= LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    fpa_mul_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .LAT       (LAT)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_s0.operand_a),
        .i_b    (r_s0.operand_b),
        .o_prod (prod)
    );

    fpa_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_s0.operand_a),
        .i_b    (r_s0.operand_b),
        .o_quot (quot)
    );

    // Select the final result
    always_comb begin
        n_out.a_less      = r_side[LAT].a_less;
        n_out.a_equal     = r_side[LAT].a_equal;
        n_out.a_greater   = r_side[LAT].a_greater;
        n_out.div_by_zero = r_side[LAT].div_by_zero;
        case (r_side[LAT].kind)
            KIND_MUL: n_out.result_raw = prod;
            KIND_DIV: n_out.result_raw = r_side[LAT].div_by_zero ? 32'sd0 : quot;
            default:  n_out.result_raw = r_side[LAT].res_simple;
        endcase
    end

    assign push = en && r_v[LAT];

    fpa_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (n_out),
        .o_full  (full),
        .o_res   (o_res)
    );

    `FPA_ASSERT_IMPL(a_one_flag, i_clk, i_rst_n, o_res.valid, $onehot({o_res.data.a_less, o_res.data.a_equal, o_res.data.a_greater}), "compare flags not exclusive")
    `FPA_ASSERT_IMPL(a_dz_zero, i_clk, i_rst_n, o_res.valid && o_res.data.div_by_zero, o_res.data.result_raw == 32'sd0, "divide by zero gave nonzero result")
    `FPA_ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, !en |=> $stable(r_v[LAT]), "pipeline moved while halted")

endmodule
